FILE: hdl/prs_pkg.sv
// Package for the card-punch row stepper sequencer.
// Holds the command, mode and register codes, the coil patterns and the shared structs.
// No dependencies.
package prs_pkg;

  localparam int COLUMNS_DEF = 8;

  localparam logic [7:0] PUNCH_DWELL_RST  = 8'd20;
  localparam logic [7:0] MOVE_DWELL_RST   = 8'd28;
  localparam logic [7:0] PUNCH_CYCLES_RST = 8'd50;
  localparam logic [7:0] MOVE_CYCLES_RST  = 8'd56;
  localparam logic [3:0] RETURN_ROWS_RST  = 4'd5;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_RETURN = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PUNCH = 3'd1,
    MODE_YFWD  = 3'd2,
    MODE_YBACK = 3'd3,
    MODE_XFWD  = 3'd4,
    MODE_XBACK = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_PUNCH_DWELL  = 3'd0,
    REG_MOVE_DWELL   = 3'd1,
    REG_PUNCH_CYCLES = 3'd2,
    REG_MOVE_CYCLES  = 3'd3,
    REG_RETURN_ROWS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] punch_dwell;
    logic [7:0] move_dwell;
    logic [7:0] punch_cycles;
    logic [7:0] move_cycles;
    logic [3:0] return_rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  row_bits;
    mode_t       mode;
    logic [1:0]  phase;
    logic [11:0] cycle_count;
    logic [7:0]  dwell_count;
    logic [3:0]  punch_hold;
    logic [3:0]  y_hold;
    logic [3:0]  x_hold;
  } seq_state_t;

  // packed so that punch_coils lands in the lowest bits
  typedef struct packed {
    logic       done;
    logic       busy;
    logic [3:0] x_coils;
    logic [3:0] y_coils;
    logic [3:0] punch_coils;
  } res_t;

  function automatic logic [3:0] pat_fwd(input logic [1:0] p);
    logic [3:0] v;
    case (p)
      2'd0:    v = 4'h1;
      2'd1:    v = 4'h4;
      2'd2:    v = 4'h2;
      default: v = 4'h8;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pat_rev(input logic [1:0] p);
    logic [3:0] v;
    case (p)
      2'd0:    v = 4'h8;
      2'd1:    v = 4'h2;
      2'd2:    v = 4'h4;
      default: v = 4'h1;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/prs_step.sv
// Next-state and result logic for one beat of the row stepper sequencer.
// Depends on prs_pkg.
module prs_step #(
  parameter int COLUMNS = prs_pkg::COLUMNS_DEF
) (
  input  prs_pkg::cfg_t                 cfg,
  input  prs_pkg::seq_state_t           st,
  input  logic [$clog2(COLUMNS)-1:0]    column,
  input  prs_pkg::op_t                  op,
  input  logic [3:0]                    first_value,
  input  logic [2:0]                    second_value,
  output prs_pkg::seq_state_t           st_nxt,
  output logic [$clog2(COLUMNS)-1:0]    column_nxt,
  output logic                          has_res,
  output prs_pkg::res_t                 res
);

  localparam int CW = $clog2(COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

  function automatic logic col_bit(input logic [CW-1:0] c, input logic [7:0] rb);
    logic [3:0] c4;
    c4 = 4'(c);
    return !c4[3] && rb[c4[2:0]];
  endfunction

  logic [7:0]    dwell_lim;
  logic [11:0]   total;
  logic          dwell_hit;
  logic [1:0]    phase_inc;
  logic [11:0]   cyc_inc;
  logic          seg_end;
  logic          last;
  logic [CW-1:0] col_inc;

  always_comb begin
    unique case (st.mode)
      prs_pkg::MODE_PUNCH: begin
        dwell_lim = cfg.punch_dwell;
        total     = {4'd0, cfg.punch_cycles};
      end
      prs_pkg::MODE_YBACK: begin
        dwell_lim = cfg.move_dwell;
        total     = 12'(COLUMNS) * {4'd0, cfg.move_cycles};
      end
      prs_pkg::MODE_XBACK: begin
        dwell_lim = cfg.move_dwell;
        total     = {8'd0, cfg.return_rows} * {4'd0, cfg.move_cycles};
      end
      default: begin
        dwell_lim = cfg.move_dwell;
        total     = {4'd0, cfg.move_cycles};
      end
    endcase
  end

  assign dwell_hit = ({1'b0, st.dwell_count} + 9'd1) >= {1'b0, dwell_lim};
  assign phase_inc = st.phase + 2'd1;
  assign cyc_inc   = st.cycle_count + 12'd1;
  assign seg_end   = cyc_inc >= total;
  assign last      = column == LAST_COL;
  assign col_inc   = column + 1'b1;

  always_comb begin
    st_nxt     = st;
    column_nxt = column;
    has_res    = 1'b0;
    res.done   = 1'b0;
    res.busy   = 1'b0;
    case (op)
      prs_pkg::OP_START: begin
        if (st.mode == prs_pkg::MODE_IDLE) begin
          st_nxt.row_bits    = {second_value, first_value, 1'b1};
          column_nxt         = '0;
          // column 0 always carries a set bit and is never the last column
          st_nxt.mode        = prs_pkg::MODE_PUNCH;
          st_nxt.phase       = 2'd0;
          st_nxt.cycle_count = '0;
          st_nxt.dwell_count = '0;
        end
      end
      prs_pkg::OP_RETURN: begin
        if (st.mode == prs_pkg::MODE_IDLE) begin
          st_nxt.mode        = prs_pkg::MODE_XBACK;
          st_nxt.phase       = 2'd0;
          st_nxt.cycle_count = '0;
          st_nxt.dwell_count = '0;
        end
      end
      prs_pkg::OP_TICK: begin
        has_res = 1'b1;
        if (st.mode != prs_pkg::MODE_IDLE) begin
          res.busy = 1'b1;
          unique case (st.mode)
            prs_pkg::MODE_PUNCH: st_nxt.punch_hold = prs_pkg::pat_fwd(st.phase);
            prs_pkg::MODE_YFWD:  st_nxt.y_hold     = prs_pkg::pat_fwd(st.phase);
            prs_pkg::MODE_YBACK: st_nxt.y_hold     = prs_pkg::pat_rev(st.phase);
            prs_pkg::MODE_XFWD:  st_nxt.x_hold     = prs_pkg::pat_rev(st.phase);
            default:             st_nxt.x_hold     = prs_pkg::pat_fwd(st.phase);
          endcase
          if (dwell_hit) begin
            st_nxt.dwell_count = '0;
            st_nxt.phase       = phase_inc;
            if (phase_inc == 2'd0) begin
              st_nxt.cycle_count = cyc_inc;
              if (seg_end) begin
                st_nxt.cycle_count = '0;
                unique case (st.mode)
                  prs_pkg::MODE_PUNCH: begin
                    st_nxt.mode = last ? prs_pkg::MODE_YBACK : prs_pkg::MODE_YFWD;
                  end
                  prs_pkg::MODE_YFWD: begin
                    if (!last) begin
                      column_nxt  = col_inc;
                      st_nxt.mode = (col_inc != LAST_COL && col_bit(col_inc, st.row_bits)) ?
                                    prs_pkg::MODE_PUNCH : prs_pkg::MODE_YFWD;
                    end else begin
                      st_nxt.mode = col_bit(column, st.row_bits) ?
                                    prs_pkg::MODE_PUNCH : prs_pkg::MODE_YBACK;
                    end
                  end
                  prs_pkg::MODE_YBACK: st_nxt.mode = prs_pkg::MODE_XFWD;
                  default: begin
                    st_nxt.mode = prs_pkg::MODE_IDLE;
                    res.done    = 1'b1;
                  end
                endcase
              end
            end
          end else begin
            st_nxt.dwell_count = st.dwell_count + 8'd1;
          end
        end
      end
      default: ;
    endcase
    res.punch_coils = st_nxt.punch_hold;
    res.y_coils     = st_nxt.y_hold;
    res.x_coils     = st_nxt.x_hold;
  end

endmodule

FILE: hdl/punch_row_stepper_sequencer_core.sv
// Top level of the card-punch row stepper sequencer.
// Depends on prs_pkg and prs_step.
//
// Usage:
//   Slave channel (in_*): one beat per command or time tick. in_tuser carries the op
//   (start row, tick, start X return); in_tdata carries the row values.
//   Master channel (out_*): one beat per tick with the held punch, Y and X coil
//   patterns plus busy and done flags. Start and return commands give no beat.
//   Config port: cfg_wr_en, cfg_index, cfg_wdata; write only while no beat is in flight.
// Timing:
//   A beat is taken into an input register, then processed from there by
//   one pass of next-state logic that updates the sequence state and loads the
//   output register. out_tvalid rises once a tick has passed through the input
//   register and its result is loaded into the output register.
//   Throughput is one beat per cycle while the output is not stalled.
// Reset:
//   rst_n low clears the sequence to idle, zeroes all held patterns and loads
//   the register defaults (dwell 20/28, cycles 50/56, return rows 5).
// Backpressure:
//   A pending result holds in the output register while out_tready is low; start
//   and return commands keep flowing, and the first tick that reaches the input
//   register holds there and drops in_tready.
module punch_row_stepper_sequencer_core #(
  parameter int COLUMNS = prs_pkg::COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] first_value, [6:4] second_value, [7] zero
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  // [3:0] punch_coils, [7:4] y_coils, [11:8] x_coils, [12] busy_res, [13] done_res
  output logic [15:0] out_tdata,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int CW = $clog2(COLUMNS);

  prs_pkg::cfg_t       cfg_r;
  prs_pkg::seq_state_t st_r;
  prs_pkg::seq_state_t st_nxt;
  logic [CW-1:0]       column_r;
  logic [CW-1:0]       column_nxt;

  logic                s1_v_r;
  prs_pkg::op_t        s1_op_r;
  logic [3:0]          s1_first_r;
  logic [2:0]          s1_second_r;

  logic                out_v_r;
  prs_pkg::res_t       out_res_r;
  prs_pkg::res_t       res_nxt;
  logic                has_res;

  logic                in_acc;
  logic                proc;

  prs_step #(
    .COLUMNS(COLUMNS)
  ) u_step (
    .cfg          (cfg_r),
    .st           (st_r),
    .column       (column_r),
    .op           (s1_op_r),
    .first_value  (s1_first_r),
    .second_value (s1_second_r),
    .st_nxt       (st_nxt),
    .column_nxt   (column_nxt),
    .has_res      (has_res),
    .res          (res_nxt)
  );

  assign proc      = s1_v_r && (!has_res || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.punch_dwell  <= prs_pkg::PUNCH_DWELL_RST;
      cfg_r.move_dwell   <= prs_pkg::MOVE_DWELL_RST;
      cfg_r.punch_cycles <= prs_pkg::PUNCH_CYCLES_RST;
      cfg_r.move_cycles  <= prs_pkg::MOVE_CYCLES_RST;
      cfg_r.return_rows  <= prs_pkg::RETURN_ROWS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prs_pkg::REG_PUNCH_DWELL:  cfg_r.punch_dwell  <= cfg_wdata;
        prs_pkg::REG_MOVE_DWELL:   cfg_r.move_dwell   <= cfg_wdata;
        prs_pkg::REG_PUNCH_CYCLES: cfg_r.punch_cycles <= cfg_wdata;
        prs_pkg::REG_MOVE_CYCLES:  cfg_r.move_cycles  <= cfg_wdata;
        prs_pkg::REG_RETURN_ROWS:  cfg_r.return_rows  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      st_r     <= '0;
      column_r <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (proc) begin
        s1_v_r <= 1'b0;
      end
      if (proc) begin
        st_r     <= st_nxt;
        column_r <= column_nxt;
      end
      if (proc && has_res) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= prs_pkg::op_t'(in_tuser);
      s1_first_r  <= in_tdata[3:0];
      s1_second_r <= in_tdata[6:4];
    end
    if (proc && has_res) begin
      out_res_r <= res_nxt;
    end
  end

  a_done_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_res_r.done || out_res_r.busy))
    else $error("done flag without busy flag");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && has_res && res_nxt.done) |=> (st_r.mode == prs_pkg::MODE_IDLE))
    else $error("sequence not idle after final tick");

  a_hold_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(st_r.punch_hold) && $onehot0(st_r.y_hold) && $onehot0(st_r.x_hold))
    else $error("coil hold pattern not one-hot");

  a_idle_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == prs_pkg::MODE_IDLE) |-> (st_r.cycle_count == '0 && st_r.dwell_count == '0))
    else $error("counters not clear while idle");

endmodule
